// ----- design/bsmh_pkg.sv -----
// bsmh_pkg: shared constants and control types for the box stacking block.
// Used by bsmh_chain_unit and box_stack_max_height; depends on nothing.
package bsmh_pkg;

  localparam int MAX_BOXES_DEF = 32;
  localparam int DIM_BITS_DEF  = 16;
  localparam int OUT_W         = 24;
  localparam int ORIENT_W      = 3;

  // Orientation slots of one box, named by the (x, y, h) order of (a, b, c)
  localparam logic [ORIENT_W-1:0] ORI_BCA = 3'd0;
  localparam logic [ORIENT_W-1:0] ORI_CBA = 3'd1;
  localparam logic [ORIENT_W-1:0] ORI_ACB = 3'd2;
  localparam logic [ORIENT_W-1:0] ORI_CAB = 3'd3;
  localparam logic [ORIENT_W-1:0] ORI_BAC = 3'd4;
  localparam logic [ORIENT_W-1:0] ORI_ABC = 3'd5;

  typedef struct packed {
    logic init;        // drop the current orientation, a new set begins
    logic scan_start;  // clear the running best and the selection
    logic take;        // one orientation read from memory is on the bus
    logic advance;     // move the selected orientation into current
  } bsmh_cmd_t;

  typedef struct packed {
    logic cur_valid;
    logic sel_found;
  } bsmh_stat_t;

endpackage

// ----- design/bsmh_ram.sv -----
// bsmh_ram: generic single-write, single-read memory with registered read.
// No dependencies.
module bsmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bsmh_chain_unit.sv -----
// bsmh_chain_unit: shared compare unit of the box stacking block.
// Holds the current orientation, its best supporting height and the next
// orientation in descending (x, index) order. Depends on bsmh_pkg.
module bsmh_chain_unit import bsmh_pkg::*; #(
  parameter int DIM_BITS = DIM_BITS_DEF,
  parameter int IDX_W    = 8,
  parameter int BH_W     = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  bsmh_cmd_t           cmd,
  input  logic [DIM_BITS-1:0] rd_x,
  input  logic [DIM_BITS-1:0] rd_y,
  input  logic [DIM_BITS-1:0] rd_h,
  input  logic [BH_W-1:0]     rd_bh,
  input  logic [IDX_W-1:0]    rd_idx,
  output bsmh_stat_t          stat,
  output logic [DIM_BITS-1:0] cur_h,
  output logic [IDX_W-1:0]    cur_idx,
  output logic [BH_W-1:0]     below
);

  logic                cur_valid;
  logic                sel_found;
  logic [DIM_BITS-1:0] cur_x;
  logic [DIM_BITS-1:0] cur_y;
  logic [DIM_BITS-1:0] sel_x;
  logic [DIM_BITS-1:0] sel_y;
  logic [DIM_BITS-1:0] sel_h;
  logic [IDX_W-1:0]    sel_idx;
  logic                fits;
  logic                under_cur;
  logic                over_sel;
  logic                pick;

  always_comb begin
    // Only already-finished orientations can have a strictly larger x
    fits      = cur_valid && (rd_x > cur_x) && (rd_y > cur_y) && (rd_bh > below);
    under_cur = !cur_valid || ({rd_x, rd_idx} < {cur_x, cur_idx});
    over_sel  = !sel_found || ({rd_x, rd_idx} > {sel_x, sel_idx});
    pick      = cmd.take && under_cur && over_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      sel_found <= 1'b0;
    end else begin
      if (cmd.init) begin
        cur_valid <= 1'b0;
      end else if (cmd.advance) begin
        cur_valid <= 1'b1;
      end
      if (cmd.scan_start) begin
        sel_found <= 1'b0;
      end else if (pick) begin
        sel_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      cur_x   <= sel_x;
      cur_y   <= sel_y;
      cur_h   <= sel_h;
      cur_idx <= sel_idx;
    end
    if (cmd.scan_start) begin
      below <= '0;
    end else if (cmd.take && fits) begin
      below <= rd_bh;
    end
    if (pick) begin
      sel_x   <= rd_x;
      sel_y   <= rd_y;
      sel_h   <= rd_h;
      sel_idx <= rd_idx;
    end
  end

  assign stat.cur_valid = cur_valid;
  assign stat.sel_found = sel_found;

endmodule

// ----- design/box_stack_max_height.sv -----
// Box stacking: tallest tower over the six orientations of every loaded box.
// Each accepted request loads one box, up to MAX_BOXES; the request flagged
// last_box runs the chain computation and yields one max_height result.
// Loading a box makes six orientation writes through the single memory
// write port, then returns to idle; a box beyond MAX_BOXES is dropped. With
// n = 6 * boxes orientations, the final computation runs n + 1 passes over
// the orientation memory, each made of n reads, a drain of the registered
// read and an update step, then posts the result from the done state. The
// pass count and length come from the one read port of the orientation and
// height memories and the single compare unit that walks them. Each pass
// finishes the orientation with the next largest x (ties broken by index)
// and picks its successor, so every orientation that can carry it is already
// done. Heights add at full width; max_height saturates at all ones where
// that width exceeds OUT_W. Loading of further boxes goes on while a result
// waits on the output; the next last_box request holds its result until the
// output register frees.
// Depends on bsmh_pkg, bsmh_ram and bsmh_chain_unit.
module box_stack_max_height import bsmh_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF,
  parameter int DIM_BITS  = DIM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [DIM_BITS-1:0] dim_a,
  input  logic [DIM_BITS-1:0] dim_b,
  input  logic [DIM_BITS-1:0] dim_c,
  input  logic                last_box,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_W-1:0]    max_height
);

  localparam int ORIENTS = 6 * MAX_BOXES;
  localparam int IDX_W   = $clog2(ORIENTS);
  localparam int J_W     = $clog2(ORIENTS + 1);
  localparam int CNT_W   = $clog2(MAX_BOXES + 1);
  localparam int BH_W    = DIM_BITS + $clog2(ORIENTS + 1);
  localparam int OW_W    = 3 * DIM_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]          state;
  logic [CNT_W-1:0]    count;
  logic [ORIENT_W-1:0] k;
  logic [J_W-1:0]      j;
  logic                pipe_valid;
  logic [IDX_W-1:0]    pipe_idx;
  logic [DIM_BITS-1:0] box_a;
  logic [DIM_BITS-1:0] box_b;
  logic [DIM_BITS-1:0] box_c;
  logic                box_last;
  logic [BH_W-1:0]     ans;

  logic                in_fire;
  logic                start_compute;
  logic [J_W-1:0]      n_orients;
  logic                scan_issue;
  logic                scan_done;
  logic [IDX_W-1:0]    load_addr;
  logic [OW_W-1:0]     orient_wdata;
  logic [OW_W-1:0]     orient_rdata;
  logic                orient_we;
  logic                bh_we;
  logic [BH_W-1:0]     bh_rdata;
  logic [BH_W-1:0]     upd_sum;
  logic [OUT_W-1:0]    sat_height;
  bsmh_cmd_t           cmd;
  bsmh_stat_t          stat;
  logic [DIM_BITS-1:0] cur_h;
  logic [IDX_W-1:0]    cur_idx;
  logic [BH_W-1:0]     below;

  // Clamp the running maximum to the result width
  generate
    if (BH_W > OUT_W) begin : g_sat
      assign sat_height = (ans[BH_W-1:OUT_W] != '0) ? '1 : ans[OUT_W-1:0];
    end else begin : g_nosat
      assign sat_height = OUT_W'(ans);
    end
  endgenerate

  always_comb begin
    in_ready      = (state == ST_IDLE);
    in_fire       = in_valid && in_ready;
    n_orients     = J_W'({count, 2'b00}) + J_W'({count, 1'b0});
    load_addr     = IDX_W'({count, 2'b00}) + IDX_W'({count, 1'b0}) + IDX_W'(k);
    orient_we     = (state == ST_LOAD);
    scan_issue    = (state == ST_SCAN) && (j < n_orients);
    scan_done     = (state == ST_SCAN) && (j == n_orients) && !pipe_valid;
    upd_sum       = below + BH_W'(cur_h);
    bh_we         = (state == ST_UPD) && stat.cur_valid;
    // A set starts computing after its last box is stored, or at once when
    // the last box is dropped for capacity
    start_compute = ((state == ST_LOAD) && (k == ORI_ABC) && box_last) ||
                    (in_fire && last_box && (count >= CNT_W'(MAX_BOXES)));
    cmd.init       = start_compute;
    cmd.advance    = (state == ST_UPD) && stat.sel_found;
    cmd.scan_start = start_compute || cmd.advance;
    cmd.take       = pipe_valid;

    // Orientation as {x, y, h}
    case (k)
      ORI_BCA: orient_wdata = {box_b, box_c, box_a};
      ORI_CBA: orient_wdata = {box_c, box_b, box_a};
      ORI_ACB: orient_wdata = {box_a, box_c, box_b};
      ORI_CAB: orient_wdata = {box_c, box_a, box_b};
      ORI_BAC: orient_wdata = {box_b, box_a, box_c};
      ORI_ABC: orient_wdata = {box_a, box_b, box_c};
      default: orient_wdata = {box_a, box_b, box_c};
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      pipe_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      pipe_valid <= scan_issue;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (count < CNT_W'(MAX_BOXES)) begin
              state <= ST_LOAD;
            end else if (last_box) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_LOAD: begin
          if (k == ORI_ABC) begin
            count <= count + 1'b1;
            state <= box_last ? ST_SCAN : ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          state <= stat.sel_found ? ST_SCAN : ST_DONE;
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (!out_valid) begin
            out_valid <= 1'b1;
            count     <= '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      box_a    <= dim_a;
      box_b    <= dim_b;
      box_c    <= dim_c;
      box_last <= last_box;
      k        <= ORI_BCA;
    end else if (state == ST_LOAD) begin
      k <= k + 1'b1;
    end
    if (start_compute || cmd.advance) begin
      j <= '0;
    end else if (scan_issue) begin
      j <= j + 1'b1;
    end
    pipe_idx <= j[IDX_W-1:0];
    if (start_compute) begin
      ans <= '0;
    end else if (bh_we && (upd_sum > ans)) begin
      ans <= upd_sum;
    end
    if ((state == ST_DONE) && !out_valid) begin
      max_height <= sat_height;
    end
  end

  bsmh_ram #(
    .WIDTH (OW_W),
    .DEPTH (ORIENTS)
  ) u_orient_ram (
    .clk   (clk),
    .we    (orient_we),
    .waddr (load_addr),
    .wdata (orient_wdata),
    .raddr (j[IDX_W-1:0]),
    .rdata (orient_rdata)
  );

  bsmh_ram #(
    .WIDTH (BH_W),
    .DEPTH (ORIENTS)
  ) u_best_ram (
    .clk   (clk),
    .we    (bh_we),
    .waddr (cur_idx),
    .wdata (upd_sum),
    .raddr (j[IDX_W-1:0]),
    .rdata (bh_rdata)
  );

  bsmh_chain_unit #(
    .DIM_BITS (DIM_BITS),
    .IDX_W    (IDX_W),
    .BH_W     (BH_W)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_x    (orient_rdata[OW_W-1:2*DIM_BITS]),
    .rd_y    (orient_rdata[2*DIM_BITS-1:DIM_BITS]),
    .rd_h    (orient_rdata[DIM_BITS-1:0]),
    .rd_bh   (bh_rdata),
    .rd_idx  (pipe_idx),
    .stat    (stat),
    .cur_h   (cur_h),
    .cur_idx (cur_idx),
    .below   (below)
  );

  // A result appears only when a computation has finished
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result posted outside of completion");

  // Box count stays within capacity
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BOXES))
    else $error("box count beyond capacity");

  // A last_box request always blocks further requests on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_box |=> !in_ready)
    else $error("request accepted right after last box");

  // The scan pointer never runs past the loaded orientations
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> j <= n_orients)
    else $error("scan pointer out of range");

endmodule
